// ----- src/mawd_pkg.sv -----
// shared types, widths and codes for the moving average with deviation block
package mawd_pkg;

	localparam int MAX_WINDOW_DEF = 64;

	localparam int SAMPLE_W  = 16;
	localparam int LEN_W     = 7;
	localparam int SUM_W     = 23;
	localparam int SQ_W      = 32;
	localparam int SQSUM_W   = 38;
	localparam int ROOT_W    = SQSUM_W / 2;
	localparam int ALU_W     = ROOT_W + 3;
	localparam int MUL_W     = SAMPLE_W + 1;
	localparam int CNT_W     = 6;
	localparam int CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0] DIV_SUM_STEPS = CNT_W'(SUM_W);
	localparam logic [CNT_W-1:0] DIV_SQ_STEPS  = CNT_W'(SQSUM_W);
	localparam logic [CNT_W-1:0] SQRT_STEPS    = CNT_W'(ROOT_W);

	localparam logic [LEN_W-1:0] WINDOW_LENGTH_RST = LEN_W'(16);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_ENABLE  = CFG_IDX_W'(1);

	// request modes
	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_FILL = 1'b1;

	typedef struct packed {
		logic                       mode;
		logic signed [SAMPLE_W-1:0] sample_value;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] average;
		logic        [SAMPLE_W-1:0] deviation;
		logic signed [SAMPLE_W-1:0] oldest_sample;
		logic signed [SAMPLE_W-1:0] newest_sample;
	} result_t;

	typedef enum logic [3:0] {
		ST_FILL,
		ST_IDLE,
		ST_READ,
		ST_DIV_SUM,
		ST_AVG,
		ST_SQUARE,
		ST_SQSUM,
		ST_DIV_SQ,
		ST_SQRT,
		ST_EMIT
	} state_t;

endpackage

// ----- src/moving_average_with_deviation_top.sv -----
// moving average with windowed deviation: sequencer, rings and shared divide / root unit
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  sample  | in        | sample_valid/sample_stall | mawd_pkg::sample_t (mode, value)
//  result  | out       | result_valid/result_stall | mawd_pkg::result_t (4 fields)
//  cfg     | in        | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
//  a push request runs one subtract-compare unit through 23 divide steps for the average;
//  with deviation on it then runs 38 divide steps and 19 root steps for the deviation,
//  one step per cycle.
//  a fill request sweeps all MAX_WINDOW ring slots, one slot per cycle, and gives no result.
//  after reset the same sweep clears both rings, with sample_stall high.
//  the result sits in its own register, so the next request is taken while it waits;
//  a finished result only waits in the emit state if the previous one is still stalled.
module moving_average_with_deviation_top #(
	parameter int MAX_WINDOW = mawd_pkg::MAX_WINDOW_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// sample requests
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  mawd_pkg::sample_t              sample,
	// results
	output logic                           result_valid,
	input  logic                           result_stall,
	output mawd_pkg::result_t              result,
	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mawd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mawd_pkg::LEN_W-1:0]     cfg_data
);

	localparam int SAMPLE_W = mawd_pkg::SAMPLE_W;
	localparam int LEN_W    = mawd_pkg::LEN_W;
	localparam int SUM_W    = mawd_pkg::SUM_W;
	localparam int SQ_W     = mawd_pkg::SQ_W;
	localparam int SQSUM_W  = mawd_pkg::SQSUM_W;
	localparam int ROOT_W   = mawd_pkg::ROOT_W;
	localparam int ALU_W    = mawd_pkg::ALU_W;
	localparam int MUL_W    = mawd_pkg::MUL_W;
	localparam int CNT_W    = mawd_pkg::CNT_W;

	localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CMP_W  = (SLOT_W > LEN_W) ? SLOT_W : LEN_W;
	localparam int LEN_CAP = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;
	localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(LEN_CAP);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_WINDOW - 1);

	// ---------------------------------------------------------------- state
	mawd_pkg::state_t state_q, state_d;

	logic [LEN_W-1:0]           window_length_q;
	logic                       sigma_enable_q;
	logic [SLOT_W-1:0]          write_slot_q;
	logic [SLOT_W-1:0]          fill_idx_q;
	logic signed [SAMPLE_W-1:0] fill_val_q;
	logic [SUM_W-1:0]           window_sum_q;
	logic [SQSUM_W-1:0]         square_sum_q;
	logic                       result_valid_q;
	mawd_pkg::result_t          result_q;

	// per-request working registers
	logic signed [SAMPLE_W-1:0] val_q;
	logic [SLOT_W-1:0]          slot_q;
	logic [SQ_W-1:0]            old_sq_q;
	logic [SQ_W-1:0]            sq_q;
	logic signed [SAMPLE_W-1:0] avg_q;
	logic [SAMPLE_W-1:0]        dev_q;
	logic [SQSUM_W-1:0]         work_q;
	logic [ALU_W-1:0]           rem_q;
	logic [ROOT_W-1:0]          root_q;
	logic [CNT_W-1:0]           cnt_q;

	// ring memories
	logic signed [SAMPLE_W-1:0] sample_mem [MAX_WINDOW];
	logic [SQ_W-1:0]            square_mem [MAX_WINDOW];
	logic signed [SAMPLE_W-1:0] sample_rd_q;
	logic [SQ_W-1:0]            square_rd_q;

	// controls from the sequencer
	logic                       smp_we;
	logic                       sq_we;
	logic [SLOT_W-1:0]          mem_wr_addr;
	logic [SLOT_W-1:0]          mem_rd_addr;
	logic signed [SAMPLE_W-1:0] smp_wdata;
	logic [SQ_W-1:0]            sq_wdata;
	logic                       in_accept;
	logic                       emit_load;
	logic                       cnt_last;

	// ---------------------------------------------------------------- length and slots
	logic [LEN_W-1:0]  len_eff;
	logic [SLOT_W-1:0] slot_sel;
	logic [CMP_W-1:0]  next_ext;
	logic [SLOT_W-1:0] next_slot;

	// clamp the programmed length to 1..MAX_WINDOW
	always_comb begin
		if (window_length_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (window_length_q > LEN_MAX) begin
			len_eff = LEN_MAX;
		end else begin
			len_eff = window_length_q;
		end
	end

	// a stale write slot after a shorter length falls back to slot 0
	assign slot_sel  = (CMP_W'(write_slot_q) < CMP_W'(len_eff)) ? write_slot_q : '0;
	assign next_ext  = CMP_W'(slot_q) + CMP_W'(1);
	assign next_slot = (next_ext >= CMP_W'(len_eff)) ? '0 : next_ext[SLOT_W-1:0];

	// ---------------------------------------------------------------- window sum update
	logic [SUM_W-1:0] ws_new;
	logic [SUM_W-1:0] ws_mag;

	assign ws_new = window_sum_q
		- {{(SUM_W-SAMPLE_W){sample_rd_q[SAMPLE_W-1]}}, sample_rd_q}
		+ {{(SUM_W-SAMPLE_W){val_q[SAMPLE_W-1]}}, val_q};
	assign ws_mag = ws_new[SUM_W-1] ? (~ws_new + SUM_W'(1)) : ws_new;

	// ---------------------------------------------------------------- shared multiplier
	// fill: length times value; deviation: square of (average - sample)
	logic signed [MUL_W-1:0]   mul_a;
	logic signed [MUL_W-1:0]   mul_b;
	logic signed [2*MUL_W-1:0] mul_p;
	logic signed [MUL_W-1:0]   avg_diff;

	assign avg_diff = {avg_q[SAMPLE_W-1], avg_q} - {val_q[SAMPLE_W-1], val_q};

	always_comb begin
		if (state_q == mawd_pkg::ST_IDLE) begin
			mul_a = $signed({{(MUL_W-LEN_W){1'b0}}, len_eff});
			mul_b = {sample.sample_value[SAMPLE_W-1], sample.sample_value};
		end else begin
			mul_a = avg_diff;
			mul_b = avg_diff;
		end
	end

	assign mul_p = mul_a * mul_b;

	// ---------------------------------------------------------------- shared subtract-compare
	// restoring divide step (one quotient bit) or digit-by-digit root step (one root bit)
	logic [ALU_W-1:0] div_rem;
	logic [ALU_W-1:0] div_den;
	logic [ALU_W-1:0] rt_rem;
	logic [ALU_W-1:0] rt_trial;
	logic [ALU_W-1:0] alu_a;
	logic [ALU_W-1:0] alu_b;
	logic [ALU_W:0]   alu_diff;
	logic             alu_ge;
	logic [ALU_W-1:0] rem_step;
	logic [ROOT_W-1:0] root_step;

	assign div_rem  = {rem_q[ALU_W-2:0], work_q[SQSUM_W-1]};
	assign div_den  = ALU_W'(len_eff);
	assign rt_rem   = {rem_q[ALU_W-3:0], work_q[SQSUM_W-1 -: 2]};
	assign rt_trial = ALU_W'({root_q, 2'b01});

	assign alu_a    = (state_q == mawd_pkg::ST_SQRT) ? rt_rem : div_rem;
	assign alu_b    = (state_q == mawd_pkg::ST_SQRT) ? rt_trial : div_den;
	assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
	assign alu_ge   = ~alu_diff[ALU_W];
	assign rem_step = alu_ge ? alu_diff[ALU_W-1:0] : alu_a;
	assign root_step = {root_q[ROOT_W-2:0], alu_ge};

	assign cnt_last = (cnt_q == CNT_W'(1));

	// ---------------------------------------------------------------- average and deviation
	logic signed [SUM_W:0]      avg_full;
	logic                       avg_hi;
	logic                       avg_lo;
	logic signed [SAMPLE_W-1:0] avg_sat;
	logic [SAMPLE_W-1:0]        dev_sat;
	logic [SQSUM_W-1:0]         sqsum_new;

	// quotient magnitude with the sign of the sum, truncated toward zero
	assign avg_full = window_sum_q[SUM_W-1] ? -$signed({1'b0, work_q[SUM_W-1:0]})
	                                        :  $signed({1'b0, work_q[SUM_W-1:0]});
	assign avg_hi = ~avg_full[SUM_W] & (|avg_full[SUM_W-1:SAMPLE_W-1]);
	assign avg_lo = avg_full[SUM_W] & ~(&avg_full[SUM_W-1:SAMPLE_W-1]);

	always_comb begin
		if (avg_hi) begin
			avg_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end else if (avg_lo) begin
			avg_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			avg_sat = avg_full[SAMPLE_W-1:0];
		end
	end

	assign dev_sat = (|root_step[ROOT_W-1:SAMPLE_W]) ? '1 : root_step[SAMPLE_W-1:0];

	assign sqsum_new = square_sum_q - SQSUM_W'(old_sq_q) + SQSUM_W'(sq_q);

	// ---------------------------------------------------------------- sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mawd_pkg::ST_FILL: begin
				if (fill_idx_q == SLOT_LAST) begin
					state_d = mawd_pkg::ST_IDLE;
				end
			end
			mawd_pkg::ST_IDLE: begin
				if (sample_valid) begin
					state_d = (sample.mode == mawd_pkg::MODE_FILL) ? mawd_pkg::ST_FILL
					                                               : mawd_pkg::ST_READ;
				end
			end
			mawd_pkg::ST_READ:    state_d = mawd_pkg::ST_DIV_SUM;
			mawd_pkg::ST_DIV_SUM: begin
				if (cnt_last) begin
					state_d = mawd_pkg::ST_AVG;
				end
			end
			mawd_pkg::ST_AVG: begin
				state_d = sigma_enable_q ? mawd_pkg::ST_SQUARE : mawd_pkg::ST_EMIT;
			end
			mawd_pkg::ST_SQUARE:  state_d = mawd_pkg::ST_SQSUM;
			mawd_pkg::ST_SQSUM:   state_d = mawd_pkg::ST_DIV_SQ;
			mawd_pkg::ST_DIV_SQ: begin
				if (cnt_last) begin
					state_d = mawd_pkg::ST_SQRT;
				end
			end
			mawd_pkg::ST_SQRT: begin
				if (cnt_last) begin
					state_d = mawd_pkg::ST_EMIT;
				end
			end
			mawd_pkg::ST_EMIT: begin
				if (emit_load) begin
					state_d = mawd_pkg::ST_IDLE;
				end
			end
			default: state_d = mawd_pkg::ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- sequencer: outputs
	always_comb begin
		sample_stall = 1'b1;
		smp_we       = 1'b0;
		sq_we        = 1'b0;
		mem_wr_addr  = slot_q;
		mem_rd_addr  = write_slot_q;
		smp_wdata    = val_q;
		sq_wdata     = sq_q;
		emit_load    = 1'b0;
		unique case (state_q)
			mawd_pkg::ST_FILL: begin
				smp_we      = 1'b1;
				sq_we       = 1'b1;
				mem_wr_addr = fill_idx_q;
				smp_wdata   = fill_val_q;
				sq_wdata    = '0;
			end
			mawd_pkg::ST_IDLE: begin
				sample_stall = 1'b0;
				mem_rd_addr  = slot_sel;
			end
			mawd_pkg::ST_READ: begin
				smp_we = 1'b1;
			end
			mawd_pkg::ST_SQSUM: begin
				sq_we = 1'b1;
			end
			mawd_pkg::ST_EMIT: begin
				emit_load = ~result_valid_q | ~result_stall;
			end
			default: ;
		endcase
	end

	assign in_accept = sample_valid & ~sample_stall;

	// ---------------------------------------------------------------- rings
	always_ff @(posedge clk) begin
		if (smp_we) begin
			sample_mem[mem_wr_addr] <= smp_wdata;
		end
		sample_rd_q <= sample_mem[mem_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (sq_we) begin
			square_mem[mem_wr_addr] <= sq_wdata;
		end
		square_rd_q <= square_mem[mem_rd_addr];
	end

	// ---------------------------------------------------------------- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= mawd_pkg::ST_FILL;
			window_length_q <= mawd_pkg::WINDOW_LENGTH_RST;
			sigma_enable_q  <= 1'b0;
			write_slot_q    <= '0;
			fill_idx_q      <= '0;
			fill_val_q      <= '0;
			window_sum_q    <= '0;
			square_sum_q    <= '0;
			result_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					mawd_pkg::CFG_WINDOW_LENGTH: window_length_q <= cfg_data;
					mawd_pkg::CFG_SIGMA_ENABLE:  sigma_enable_q  <= cfg_data[0];
					default: ;
				endcase
			end

			if (state_q == mawd_pkg::ST_FILL) begin
				fill_idx_q <= fill_idx_q + SLOT_W'(1);
			end

			// fill request: preset the sum, clear squares, restart the slot
			if (in_accept && sample.mode == mawd_pkg::MODE_FILL) begin
				fill_val_q   <= sample.sample_value;
				fill_idx_q   <= '0;
				window_sum_q <= mul_p[SUM_W-1:0];
				square_sum_q <= '0;
				write_slot_q <= '0;
			end

			if (state_q == mawd_pkg::ST_READ) begin
				window_sum_q <= ws_new;
				write_slot_q <= next_slot;
			end

			if (state_q == mawd_pkg::ST_SQSUM) begin
				square_sum_q <= sqsum_new;
			end

			if (emit_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			mawd_pkg::ST_IDLE: begin
				val_q  <= sample.sample_value;
				slot_q <= slot_sel;
			end
			mawd_pkg::ST_READ: begin
				old_sq_q <= square_rd_q;
				work_q   <= {ws_mag, {(SQSUM_W-SUM_W){1'b0}}};
				rem_q    <= '0;
				cnt_q    <= mawd_pkg::DIV_SUM_STEPS;
			end
			mawd_pkg::ST_DIV_SUM: begin
				work_q <= {work_q[SQSUM_W-2:0], alu_ge};
				rem_q  <= rem_step;
				cnt_q  <= cnt_q - CNT_W'(1);
			end
			mawd_pkg::ST_AVG: begin
				avg_q <= avg_sat;
				dev_q <= '0;
			end
			mawd_pkg::ST_SQUARE: begin
				sq_q <= mul_p[SQ_W-1:0];
			end
			mawd_pkg::ST_SQSUM: begin
				work_q <= sqsum_new;
				rem_q  <= '0;
				cnt_q  <= mawd_pkg::DIV_SQ_STEPS;
			end
			mawd_pkg::ST_DIV_SQ: begin
				work_q <= {work_q[SQSUM_W-2:0], alu_ge};
				if (cnt_last) begin
					// quotient stays in work_q as the root radicand
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= mawd_pkg::SQRT_STEPS;
				end else begin
					rem_q <= rem_step;
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			mawd_pkg::ST_SQRT: begin
				work_q <= {work_q[SQSUM_W-3:0], 2'b00};
				rem_q  <= rem_step;
				root_q <= root_step;
				cnt_q  <= cnt_q - CNT_W'(1);
				if (cnt_last) begin
					dev_q <= dev_sat;
				end
			end
			default: ;
		endcase

		if (emit_load) begin
			result_q.average       <= avg_q;
			result_q.deviation     <= dev_q;
			result_q.oldest_sample <= sample_rd_q;
			result_q.newest_sample <= val_q;
		end
	end

	// ---------------------------------------------------------------- ports
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the moving average with deviation block
`timescale 1ns / 1ps

module tb_top;

	import mawd_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 6;
	localparam int WINDOW_SLOTS  = MAX_WINDOW_DEF;
	// longest push with deviation on plus one full fill sweep, with margin
	localparam int SETTLE_CYCLES = 160;
	localparam int RANDOM_ITEMS  = 510;
	localparam int REPORT_LIMIT  = 10;
	localparam longint RUN_LIMIT_NS = 64'd10_000_000;

	// clock, reset and the block's ports, all known from time zero
	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 sample_valid = 1'b0;
	logic                 sample_stall;
	sample_t              sample_req   = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result_out;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [LEN_W-1:0]     cfg_data     = '0;

	// idling switches for the two sides, cleared for quiet stretches
	bit sender_gaps   = 1'b1;
	bit receiver_gaps = 1'b1;

	// predicted state of the averaging window
	logic signed [SAMPLE_W-1:0] window_samples [WINDOW_SLOTS];
	logic        [SQ_W-1:0]     window_squares [WINDOW_SLOTS];
	logic signed [SUM_W-1:0]    window_total;
	logic        [SQSUM_W-1:0]  squares_total;
	int unsigned                write_pos;
	logic        [LEN_W-1:0]    length_setting;
	logic                       deviation_on;

	// averages still owed by the block, oldest first
	result_t pending_averages [$];

	// run bookkeeping
	int requests_sent   = 0;
	int fills_sent      = 0;
	int results_checked = 0;
	int reg_writes      = 0;
	int mismatch_count  = 0;
	int random_settings = 0;
	int signal_level    = 0;

	moving_average_with_deviation_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample_req),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_out),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void clear_window_state();
		for (int i = 0; i < WINDOW_SLOTS; i++) begin
			window_samples[i] = '0;
			window_squares[i] = '0;
		end
		window_total   = '0;
		squares_total  = '0;
		write_pos      = 0;
		length_setting = WINDOW_LENGTH_RST;
		deviation_on   = 1'b0;
	endfunction

	// length register clamped into 1..window slots
	function automatic int unsigned active_length();
		int unsigned len;
		len = length_setting;
		if (len < 1)
			len = 1;
		if (len > WINDOW_SLOTS)
			len = WINDOW_SLOTS;
		return len;
	endfunction

	// floor square root, one result bit per trial from the top down
	function automatic logic [ROOT_W-1:0] floor_root(logic [SQSUM_W-1:0] x);
		logic [ROOT_W-1:0] root;
		logic [ROOT_W-1:0] trial;
		root = '0;
		for (int b = ROOT_W - 1; b >= 0; b--) begin
			trial = root | (ROOT_W'(1) << b);
			if (SQSUM_W'(trial) * SQSUM_W'(trial) <= x)
				root = trial;
		end
		return root;
	endfunction

	function automatic void predict_fill(logic signed [SAMPLE_W-1:0] val);
		for (int i = 0; i < WINDOW_SLOTS; i++) begin
			window_samples[i] = val;
			window_squares[i] = '0;
		end
		window_total  = SUM_W'(longint'(active_length()) * longint'(val));
		squares_total = '0;
		write_pos     = 0;
	endfunction

	function automatic result_t predict_push(logic signed [SAMPLE_W-1:0] val);
		int unsigned       len;
		int unsigned       slot;
		int unsigned       nxt;
		longint            total;
		longint            avg;
		longint            diff;
		logic [SQ_W-1:0]   sq;
		logic [ROOT_W-1:0] root;
		result_t           r;
		len = active_length();
		// a shrunk window without a fill restarts at slot zero
		slot = (write_pos < len) ? write_pos : 0;
		total = longint'(window_total) - longint'(window_samples[slot]) + longint'(val);
		window_total = total[SUM_W-1:0];
		window_samples[slot] = val;
		avg = longint'(window_total) / longint'(len);
		if (avg > 32767)
			avg = 32767;
		if (avg < -32768)
			avg = -32768;
		r.deviation = '0;
		if (deviation_on) begin
			diff = avg - longint'(val);
			if (diff < 0)
				diff = -diff;
			sq = SQ_W'(diff * diff);
			squares_total = squares_total - SQSUM_W'(window_squares[slot]) + SQSUM_W'(sq);
			window_squares[slot] = sq;
			root = floor_root(squares_total / SQSUM_W'(len));
			r.deviation = (root > ROOT_W'(16'hFFFF)) ? 16'hFFFF : root[SAMPLE_W-1:0];
		end
		nxt = slot + 1;
		if (nxt >= len)
			nxt = 0;
		write_pos = nxt;
		r.average       = avg[SAMPLE_W-1:0];
		r.oldest_sample = window_samples[nxt];
		r.newest_sample = val;
		return r;
	endfunction

	// ---------------------------------------------------------------- drivers

	// one request; valid stays up afterwards so back-to-back requests need no dip
	task automatic send_request(logic req_mode, logic signed [SAMPLE_W-1:0] val);
		sample_t req;
		req.mode         = req_mode;
		req.sample_value = val;
		if (sender_gaps) begin
			while ($urandom_range(99) < 8) begin
				sample_valid <= 1'b0;
				@(posedge clk);
			end
		end
		sample_valid <= 1'b1;
		sample_req   <= req;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		// accepted at this edge: update the predicted window
		requests_sent++;
		if (req_mode == MODE_FILL) begin
			fills_sent++;
			predict_fill(val);
		end else begin
			pending_averages.push_back(predict_push(val));
		end
	endtask

	// stop sending and wait for every owed result
	task automatic drain_results();
		sample_valid <= 1'b0;
		while (pending_averages.size() != 0)
			@(posedge clk);
	endtask

	// the bench, not the block, keeps register changes to idle times; fills end first
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
		drain_results();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		reg_writes++;
		if (idx == CFG_WINDOW_LENGTH)
			length_setting = data;
		else if (idx == CFG_SIGMA_ENABLE)
			deviation_on = data[0];
	endtask

	// mix of full-scale rails, a noisy level and raw random words
	function automatic logic signed [SAMPLE_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2, 3, 4: return SAMPLE_W'(signal_level + int'($urandom_range(511)) - 256);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(string field, int exp_v, int got_v);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("mismatch on %s at result %0d: expected %0d, got %0d",
				field, results_checked, exp_v, got_v);
	endtask

	task automatic check_result(result_t got);
		result_t want;
		if (pending_averages.size() == 0) begin
			report_mismatch("unexpected result, average", 0, int'(got.average));
		end else begin
			want = pending_averages.pop_front();
			if (got.average !== want.average)
				report_mismatch("average", int'(want.average), int'(got.average));
			if (got.deviation !== want.deviation)
				report_mismatch("deviation", int'(want.deviation), int'(got.deviation));
			if (got.oldest_sample !== want.oldest_sample)
				report_mismatch("oldest_sample", int'(want.oldest_sample),
					int'(got.oldest_sample));
			if (got.newest_sample !== want.newest_sample)
				report_mismatch("newest_sample", int'(want.newest_sample),
					int'(got.newest_sample));
		end
		results_checked++;
	endtask

	// result side: take on valid and no stall, then pick the next stall at random
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			check_result(result_out);
		result_stall <= receiver_gaps && ($urandom_range(99) < 8);
	end

	// ---------------------------------------------------------------- tests

	// default window of 16 and deviation off, pushing into the zeroed rings
	task automatic test_reset_state();
		send_request(MODE_PUSH, 16'sh7FFF);
		send_request(MODE_PUSH, 16'sh8000);
		send_request(MODE_PUSH, 16'sh0000);
		send_request(MODE_PUSH, 16'sh0001);
		send_request(MODE_PUSH, 16'shFFFF);
	endtask

	// length register at zero and at its top code both clamp; fills at a mid value and both rails
	task automatic test_register_extremes();
		write_reg(CFG_SIGMA_ENABLE, 7'd1);
		write_reg(CFG_WINDOW_LENGTH, 7'd0);
		send_request(MODE_FILL, 16'sh1234);
		send_request(MODE_PUSH, 16'sh8000);
		send_request(MODE_PUSH, 16'sh7FFF);
		write_reg(CFG_WINDOW_LENGTH, 7'd127);
		send_request(MODE_FILL, 16'sh7FFF);
		send_request(MODE_PUSH, 16'sh8000);
		send_request(MODE_PUSH, 16'sh0000);
		write_reg(CFG_WINDOW_LENGTH, 7'd64);
		send_request(MODE_FILL, 16'sh8000);
		send_request(MODE_PUSH, 16'sh7FFF);
		write_reg(CFG_SIGMA_ENABLE, 7'd0);
	endtask

	// fill at length one then grow to two without a fill: the sum runs past the
	// average range in both directions
	task automatic test_average_saturation();
		write_reg(CFG_SIGMA_ENABLE, 7'd1);
		write_reg(CFG_WINDOW_LENGTH, 7'd1);
		send_request(MODE_FILL, 16'sh8000);
		write_reg(CFG_WINDOW_LENGTH, 7'd2);
		send_request(MODE_PUSH, 16'sh7FFF);
		send_request(MODE_PUSH, 16'sh7FFF);
		write_reg(CFG_WINDOW_LENGTH, 7'd1);
		send_request(MODE_FILL, 16'sh7FFF);
		write_reg(CFG_WINDOW_LENGTH, 7'd2);
		send_request(MODE_PUSH, 16'sh8000);
		send_request(MODE_PUSH, 16'sh8000);
	endtask

	// sender holds off mid-stream until every owed result is back
	task automatic test_drain_pause();
		write_reg(CFG_WINDOW_LENGTH, 7'd8);
		send_request(MODE_FILL, pick_value());
		repeat (20)
			send_request(MODE_PUSH, pick_value());
		drain_results();
		repeat (20)
			send_request(MODE_PUSH, pick_value());
	endtask

	// random window settings; most phases start with a fill, some shrink the
	// window without one so stale slots and large squares stay in the sums
	task automatic test_random_windows();
		int unsigned      start;
		int unsigned      n;
		logic [LEN_W-1:0] len_pick;
		bit               skip_fill;
		int               phase;
		start = requests_sent;
		phase = 0;
		while (requests_sent - start < RANDOM_ITEMS) begin
			skip_fill = ($urandom_range(5) == 0);
			if (skip_fill) begin
				len_pick = LEN_W'($urandom_range(4));
			end else begin
				case ($urandom_range(7))
					0: len_pick = 7'd1;
					1: len_pick = 7'd64;
					2: len_pick = 7'd2;
					3: len_pick = 7'd0;
					4: len_pick = LEN_W'($urandom_range(127, 65));
					default: len_pick = LEN_W'($urandom_range(63, 3));
				endcase
			end
			// every fourth phase runs with neither side idling
			sender_gaps   = (phase % 4 != 1);
			receiver_gaps = (phase % 4 != 1);
			signal_level  = int'($urandom_range(65535)) - 32768;
			write_reg(CFG_SIGMA_ENABLE, LEN_W'($urandom_range(3) != 0));
			write_reg(CFG_WINDOW_LENGTH, len_pick);
			random_settings++;
			if (!skip_fill)
				send_request(MODE_FILL, pick_value());
			n = $urandom_range(70, 8);
			repeat (n) begin
				if ($urandom_range(99) < 3)
					send_request(MODE_FILL, pick_value());
				else
					send_request(MODE_PUSH, pick_value());
			end
			phase++;
		end
		sender_gaps   = 1'b1;
		receiver_gaps = 1'b1;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		clear_window_state();
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_register_extremes();
		test_average_saturation();
		test_drain_pause();
		test_random_windows();

		// let the last results out, then watch for strays
		drain_results();
		repeat (SETTLE_CYCLES)
			@(posedge clk);

		$display("covered %0d requests (%0d fills) and checked %0d averages",
			requests_sent, fills_sent, results_checked);
		$display("%0d register writes, %0d random window settings, %0d mismatches",
			reg_writes, random_settings, mismatch_count);
		if (mismatch_count == 0 && pending_averages.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// hard stop if the block hangs
	initial begin
		#(RUN_LIMIT_NS);
		$display("Regression FAIL");
		$finish;
	end

endmodule
